// ===== src/u8san_pkg.sv =====
// ----------------------------------------------------------------------------
// u8san_pkg
// Shared types, constants and byte classification for the UTF-8 byte sanitizer.
// ----------------------------------------------------------------------------
`default_nettype none

package u8san_pkg;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned CNT_W = 3;
  localparam int unsigned IDX_W = 2;

  localparam logic [7:0] MARK      = 8'h3F;
  localparam logic [7:0] ASCII_LIM = 8'h80;
  localparam logic [7:0] MASK2     = 8'hE0;
  localparam logic [7:0] LEAD2     = 8'hC0;
  localparam logic [7:0] MASK3     = 8'hF0;
  localparam logic [7:0] LEAD3     = 8'hE0;
  localparam logic [7:0] MASK4     = 8'hF8;
  localparam logic [7:0] LEAD4     = 8'hF0;
  localparam logic [7:0] CONT_MASK = 8'hC0;
  localparam logic [7:0] CONT_VAL  = 8'h80;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // 0 for an invalid lead byte, else sequence length 1..4
  function automatic logic [CNT_W-1:0] lead_len(input logic [7:0] c);
    logic [CNT_W-1:0] len;
    priority if (c < ASCII_LIM)            len = CNT_W'(1);
    else if ((c & MASK2) == LEAD2)         len = CNT_W'(2);
    else if ((c & MASK3) == LEAD3)         len = CNT_W'(3);
    else if ((c & MASK4) == LEAD4)         len = CNT_W'(4);
    else                                   len = '0;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return (c & CONT_MASK) == CONT_VAL;
  endfunction

endpackage

`default_nettype wire

// ===== src/utf8_byte_sanitizer.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_sanitizer
// Streaming UTF-8 cleaner: passes well-formed sequences, replaces bad bytes.
// ----------------------------------------------------------------------------
//  channel | signals                               | direction
//  input   | in_valid, in_ready, in_byte, in_last  | into block
//  output  | out_valid, out_ready, out_byte, out_last | out of block
//
//  One byte is accepted, then a scan sequencer examines the held buffer and
//  emits at most one output byte per cycle into the output register; an input
//  byte starts the scan from idle, which releases the output bytes it completes
//  and then returns to idle; a truncated string end goes idle with its mark.
//  The output register frees the scan only when its transaction completes,
//  so a stalled consumer holds the sequencer. in_ready is high only in idle.
//  Reset (rst, synchronous) empties the buffer and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_byte_sanitizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);
  import u8san_pkg::*;

  state_t            state, state_next;
  logic [7:0]        pend_bytes [DEPTH];
  logic [7:0]        pend_bytes_next [DEPTH];
  logic [CNT_W-1:0]  pend_count, pend_count_next;
  logic [IDX_W-1:0]  pass_cnt, pass_cnt_next;
  logic              str_last, str_last_next;

  logic              can_go;
  logic              emit;
  logic [7:0]        emit_byte;
  logic              emit_last;
  logic              shift;
  logic [CNT_W-1:0]  len;
  logic              seq_ok;

  assign in_ready = (state == ST_IDLE);
  assign can_go   = !out_valid || out_ready;
  assign len      = lead_len(pend_bytes[0]);

  always_comb begin
    seq_ok = 1'b1;
    for (int j = 1; j < DEPTH; j++) begin
      if (CNT_W'(j) < len && !is_cont(pend_bytes[j])) seq_ok = 1'b0;
    end
  end

  always_comb begin
    state_next      = state;
    pend_count_next = pend_count;
    pass_cnt_next   = pass_cnt;
    str_last_next   = str_last;
    emit            = 1'b0;
    emit_byte       = MARK;
    emit_last       = 1'b0;
    shift           = 1'b0;
    for (int i = 0; i < DEPTH; i++) pend_bytes_next[i] = pend_bytes[i];

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          pend_bytes_next[pend_count[IDX_W-1:0]] = in_byte;
          pend_count_next = pend_count + CNT_W'(1);
          str_last_next   = in_last;
          state_next      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (pass_cnt != '0) begin
          emit      = can_go;
          emit_byte = pend_bytes[0];
          shift     = can_go;
          if (can_go) pass_cnt_next = pass_cnt - IDX_W'(1);
        end else if (pend_count == '0) begin
          state_next = ST_IDLE;
        end else if (len == '0) begin
          emit  = can_go;
          shift = can_go;
        end else if (len == CNT_W'(1)) begin
          emit      = can_go;
          emit_byte = pend_bytes[0];
          shift     = can_go;
        end else if (pend_count < len) begin
          // truncated or still waiting
          if (str_last) begin
            if (can_go) begin
              emit            = 1'b1;
              emit_last       = 1'b1;
              pend_count_next = '0;
              state_next      = ST_IDLE;
            end
          end else begin
            state_next = ST_IDLE;
          end
        end else if (seq_ok) begin
          emit      = can_go;
          emit_byte = pend_bytes[0];
          shift     = can_go;
          if (can_go) pass_cnt_next = IDX_W'(len - CNT_W'(1));
        end else begin
          emit  = can_go;
          shift = can_go;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (shift) begin
      for (int i = 0; i < DEPTH - 1; i++) pend_bytes_next[i] = pend_bytes[i+1];
      pend_count_next = pend_count - CNT_W'(1);
      emit_last       = str_last && (pend_count == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_count <= '0;
      pass_cnt   <= '0;
      str_last   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_count <= pend_count_next;
      pass_cnt   <= pass_cnt_next;
      str_last   <= str_last_next;
      if (emit)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) pend_bytes[i] <= pend_bytes_next[i];
    if (emit) begin
      out_byte <= emit_byte;
      out_last <= emit_last;
    end
  end

endmodule

`default_nettype wire

// ===== bench/utf8_byte_sanitizer_checker.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_sanitizer_checker
// Watches both channels of the UTF-8 byte sanitizer, predicts the cleaned byte
// stream from every accepted input transaction and compares each accepted
// output transaction, byte and last flag, with the oldest predicted byte.
// ----------------------------------------------------------------------------
module utf8_byte_sanitizer_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            out_valid,
  input  logic            out_ready,
  input  logic [7:0]      out_byte,
  input  logic            out_last,
  output int unsigned     mismatches,
  output int unsigned     backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  import u8san_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } clean_byte_t;

  clean_byte_t clean_q[$];
  logic [7:0]  held [DEPTH];
  int unsigned held_cnt = 0;
  int unsigned errors = 0;

  assign mismatches = errors;

  task automatic report_mismatch(input string what);
    errors++;
    $display("[%0t] checker: %s", $time, what);
  endtask

  // sequence length announced by a lead byte, 0 when it cannot lead
  function automatic int unsigned span_of(input logic [7:0] c);
    if (c < ASCII_LIM) return 1;
    if ((c & MASK2) == LEAD2) return 2;
    if ((c & MASK3) == LEAD3) return 3;
    if ((c & MASK4) == LEAD4) return 4;
    return 0;
  endfunction

  function automatic void shift_held(input int unsigned k);
    if (k >= held_cnt) begin
      held_cnt = 0;
    end else begin
      for (int unsigned i = 0; i + k < held_cnt; i++) held[i] = held[i + k];
      held_cnt -= k;
    end
  endfunction

  function automatic void emit(input logic [7:0] d);
    clean_byte_t e;
    e.data = d;
    e.last = 1'b0;
    clean_q.insert(clean_q.size(), e);
  endfunction

  function automatic void sanitize_byte(input logic [7:0] b, input logic lst);
    int unsigned first;
    int unsigned len;
    logic        good;
    logic        waiting;
    first = clean_q.size();
    waiting = 1'b0;
    if (held_cnt < DEPTH) begin
      held[held_cnt] = b;
      held_cnt++;
    end
    while (held_cnt > 0 && !waiting) begin
      len = span_of(held[0]);
      if (len == 0) begin
        emit(MARK);
        shift_held(1);
      end else if (len == 1) begin
        emit(held[0]);
        shift_held(1);
      end else if (held_cnt < len) begin
        // incomplete: hold on, or collapse to one mark at end of string
        if (lst) begin
          emit(MARK);
          held_cnt = 0;
        end
        waiting = 1'b1;
      end else begin
        good = 1'b1;
        for (int unsigned j = 1; j < len; j++)
          if ((held[j] & CONT_MASK) != CONT_VAL) good = 1'b0;
        if (good) begin
          for (int unsigned j = 0; j < len; j++) emit(held[j]);
          shift_held(len);
        end else begin
          emit(MARK);
          shift_held(1);
        end
      end
    end
    if (lst && clean_q.size() > first) clean_q[clean_q.size() - 1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    clean_byte_t exp_b;
    if (rst) begin
      held_cnt = 0;
      clean_q.delete();
    end else begin
      if (in_valid && in_ready) sanitize_byte(in_byte, in_last);
      if (out_valid && out_ready) begin
        if (clean_q.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h last %0b",
                                    out_byte, out_last));
        end else begin
          exp_b = clean_q.pop_front();
          if (out_byte !== exp_b.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_byte, exp_b.data));
          if (out_last !== exp_b.last)
            report_mismatch($sformatf("out_last %0b on byte %02h, expected %0b",
                                      out_last, out_byte, exp_b.last));
        end
      end
    end
    backlog <= clean_q.size();
  end

endmodule

// ===== bench/utf8_byte_sanitizer_tb.sv =====
// ----------------------------------------------------------------------------
// utf8_byte_sanitizer_tb
// Drives strings of UTF-8 bytes into the sanitizer: a directed set of valid,
// invalid, failed and truncated sequences, then random strings that are
// mostly well formed with noise mixed in. The sender works in bursts and the
// receiver stalls on its own pattern; the checker predicts and compares.
// ----------------------------------------------------------------------------
module utf8_byte_sanitizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEMS       = 320;
  localparam int unsigned STALL_LIMIT = 3000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_CHOKE,
    RX_PULSE
  } rx_mode_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;

  int unsigned mismatches;
  int unsigned backlog;
  int unsigned sent = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  logic [7:0]  text_q[$];

  utf8_byte_sanitizer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  utf8_byte_sanitizer_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(4, 40);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_COIN:  out_ready <= 1'($urandom_range(0, 1));
      RX_CHOKE: out_ready <= ($urandom_range(0, 3) == 0);
      default:  out_ready <= (rx_left[1:0] != 2'd0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    @(negedge clk);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  task automatic idle_gap(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_byte  <= 8'($urandom);
      in_last  <= 1'($urandom);
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (backlog != 0) @(posedge clk);
  endtask

  task automatic send_text;
    foreach (text_q[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 10));
      end
      burst_left--;
      send_byte(text_q[i], i == text_q.size() - 1);
    end
  endtask

  function automatic void add_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endfunction

  // one well-formed character of 1 to 4 bytes
  function automatic void add_char();
    int unsigned len;
    len = $urandom_range(1, 4);
    case (len)
      1: add_byte(8'($urandom_range(0, 127)));
      2: add_byte(8'hC0 | 8'($urandom_range(0, 31)));
      3: add_byte(8'hE0 | 8'($urandom_range(0, 15)));
      default: add_byte(8'hF0 | 8'($urandom_range(0, 7)));
    endcase
    for (int unsigned j = 1; j < len; j++)
      add_byte(8'h80 | 8'($urandom_range(0, 63)));
  endfunction

  // a lead byte followed by too few continuation bytes
  function automatic void add_broken();
    int unsigned len;
    len = $urandom_range(2, 4);
    case (len)
      2: add_byte(8'hC0 | 8'($urandom_range(0, 31)));
      3: add_byte(8'hE0 | 8'($urandom_range(0, 15)));
      default: add_byte(8'hF0 | 8'($urandom_range(0, 7)));
    endcase
    repeat ($urandom_range(0, len - 2))
      add_byte(8'h80 | 8'($urandom_range(0, 63)));
  endfunction

  initial begin
    int unsigned pick;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // plain ASCII extremes
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
    // valid 2, 3 and 4 byte sequences
    send_byte(8'hC3, 1'b0);
    send_byte(8'hA9, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
    // stray continuation and illegal leads
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF8, 1'b1);
    // failed sequence, buffered bytes replayed
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b1);
    // truncated sequence at end of string
    send_byte(8'hC3, 1'b1);
    // truncated, held byte not a continuation
    send_byte(8'hE2, 1'b0);
    send_byte(8'h41, 1'b1);
    drain();

    while (sent < ITEMS) begin
      text_q.delete();
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) add_char();
        else if (pick < 9) add_broken();
        else add_byte(8'($urandom));
      end
      send_text();
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== utf8_byte_sanitizer.f =====
src/u8san_pkg.sv
src/utf8_byte_sanitizer.sv
bench/utf8_byte_sanitizer_checker.sv
bench/utf8_byte_sanitizer_tb.sv
